>>> design/ptu_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptu_pkg
// Shared types, codes and helpers of the two-level page table update block.
// ---------------------------------------------------------------------------
package ptu_pkg;

   // default sizes of the table structures
   localparam int unsigned DIR_ENTRIES_DEF   = 1024;
   localparam int unsigned TABLE_ENTRIES_DEF = 1024;
   localparam int unsigned TABLE_POOL_DEF    = 16;
   localparam int unsigned FRAME_BITS_DEF    = 20;

   // fixed field widths of the channels
   localparam int unsigned IDX_W    = 10;
   localparam int unsigned FRAME_W  = 20;
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_MAP    = 2'd0,
      CMD_UNMAP  = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_TABLE   = 3'd1,
      ST_MAPPED     = 3'd2,
      ST_NOT_MAPPED = 3'd3,
      ST_EXHAUSTED  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR_DIR,
      S_IDLE,
      S_DIR_CHK,
      S_CLEAR_TAB,
      S_ENT_RD,
      S_ENT_CHK,
      S_RESP
   } state_type;

   // monitor flags of the controller
   typedef struct packed {
      logic clearing;
      logic pool_full;
   } mon_type;

   // Reduce a 10-bit index modulo n (n at least 16): restoring subtract of
   // shifted copies of n, six narrow steps.
   function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] x,
                                               input int unsigned n);
      logic [15:0] r;
      logic [15:0] d;
      r = {6'd0, x};
      for (int k = 5; k >= 0; k--) begin
         d = 16'(n << k);
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> design/ptu_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ptu_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 8,
   parameter int unsigned AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/ptu_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ptu_ctrl
// Command sequencer: directory read, table allocation and clear, entry
// read-modify-write, and the result register.
// ---------------------------------------------------------------------------
module ptu_ctrl #(
   parameter int unsigned DIR_ENTRIES   = 1024,
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned TABLE_POOL    = 16,
   parameter int unsigned FRAME_BITS    = 20,
   parameter int unsigned DIR_W         = 10,
   parameter int unsigned TE_W          = 10,
   parameter int unsigned TAB_W         = 4,
   parameter int unsigned ENT_AW        = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic                          csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptu_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [31:0]                   req_virt_addr,
   input  wire logic [ptu_pkg::FRAME_W-1:0]   req_phys_frame,
   input  wire logic                          req_write_allowed,
   input  wire logic                          req_create_table,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ptu_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptu_pkg::FRAME_W-1:0]        rsp_frame,
   output logic                               rsp_present,
   output logic                               rsp_writable,
   output logic                               rsp_user_access,
   output logic                               rsp_accessed,
   output logic                               rsp_dirty,
   output logic                               dir_wr_en,
   output logic [DIR_W-1:0]                   dir_wr_addr,
   output logic [TAB_W:0]                     dir_wr_data,
   output logic                               dir_rd_en,
   output logic [DIR_W-1:0]                   dir_rd_addr,
   input  wire logic [TAB_W:0]                dir_rd_data,
   output logic                               ent_wr_en,
   output logic [ENT_AW-1:0]                  ent_addr,
   output logic [FRAME_BITS+2:0]              ent_wr_data,
   output logic                               ent_rd_en,
   input  wire logic [FRAME_BITS+2:0]         ent_rd_data,
   output ptu_pkg::mon_type                   mon
);

   import ptu_pkg::*;

   localparam int unsigned NF_W = $clog2(TABLE_POOL + 1);
   localparam logic [ENT_AW-1:0] TE_MUL = ENT_AW'(TABLE_ENTRIES);
   // entry layout
   localparam int unsigned P_BIT = FRAME_BITS;
   localparam int unsigned W_BIT = FRAME_BITS + 1;
   localparam int unsigned U_BIT = FRAME_BITS + 2;

   state_type                state_ff, state_in;
   logic [DIR_W-1:0]         dir_cnt_ff, dir_cnt_in;
   logic [TE_W-1:0]          clr_cnt_ff, clr_cnt_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [DIR_W-1:0]         didx_ff, didx_in;
   logic [TE_W-1:0]          tidx_ff, tidx_in;
   logic [FRAME_BITS-1:0]    pframe_ff, pframe_in;
   logic                     wr_ff, wr_in;
   logic                     create_ff, create_in;
   logic [TAB_W-1:0]         tab_ff, tab_in;
   logic [NF_W-1:0]          next_free_ff, next_free_in;
   logic                     kctx_ff;
   status_type               res_status_ff, res_status_in;
   logic [FRAME_BITS-1:0]    res_frame_ff, res_frame_in;
   logic                     res_present_ff, res_present_in;
   logic                     res_rw_ff, res_rw_in;
   logic                     res_user_ff, res_user_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                     rsp_present_ff, rsp_present_in;
   logic                     rsp_rw_ff, rsp_rw_in;
   logic                     rsp_user_ff, rsp_user_in;
   logic [TE_W-1:0]          ent_idx;
   logic                     pool_full;

   assign pool_full = (next_free_ff >= NF_W'(TABLE_POOL));

   // entry address: table base plus index (clear sweep or the item's index)
   assign ent_idx  = (state_ff == S_CLEAR_TAB) ? clr_cnt_ff : tidx_ff;
   assign ent_addr = ENT_AW'(tab_ff) * TE_MUL + ENT_AW'(ent_idx);

   // hold the kernel-context register
   always_ff @(posedge clock) begin
      if (reset) begin
         kctx_ff <= 1'b1;
      end else if (csr_write_en) begin
         kctx_ff <= csr_write_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR_DIR;
         dir_cnt_ff   <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_cnt_ff   <= dir_cnt_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      clr_cnt_ff     <= clr_cnt_in;
      cmd_ff         <= cmd_in;
      didx_ff        <= didx_in;
      tidx_ff        <= tidx_in;
      pframe_ff      <= pframe_in;
      wr_ff          <= wr_in;
      create_ff      <= create_in;
      tab_ff         <= tab_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_present_ff <= res_present_in;
      res_rw_ff      <= res_rw_in;
      res_user_ff    <= res_user_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_present_ff <= rsp_present_in;
      rsp_rw_ff      <= rsp_rw_in;
      rsp_user_ff    <= rsp_user_in;
   end

   // next state, memory strobes and result
   always_comb begin
      state_in       = state_ff;
      dir_cnt_in     = dir_cnt_ff;
      clr_cnt_in     = clr_cnt_ff;
      cmd_in         = cmd_ff;
      didx_in        = didx_ff;
      tidx_in        = tidx_ff;
      pframe_in      = pframe_ff;
      wr_in          = wr_ff;
      create_in      = create_ff;
      tab_in         = tab_ff;
      next_free_in   = next_free_ff;
      res_status_in  = res_status_ff;
      res_frame_in   = res_frame_ff;
      res_present_in = res_present_ff;
      res_rw_in      = res_rw_ff;
      res_user_in    = res_user_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_present_in = rsp_present_ff;
      rsp_rw_in      = rsp_rw_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      req_stall      = 1'b1;
      dir_wr_en      = 1'b0;
      dir_wr_addr    = didx_ff;
      dir_wr_data    = '0;
      dir_rd_en      = 1'b0;
      dir_rd_addr    = DIR_W'(idx_mod(req_virt_addr[31:22], DIR_ENTRIES));
      ent_wr_en      = 1'b0;
      ent_wr_data    = '0;
      ent_rd_en      = 1'b0;

      unique case (state_ff)
         // sweep the directory clear after reset
         S_CLEAR_DIR: begin
            dir_wr_en   = 1'b1;
            dir_wr_addr = dir_cnt_ff;
            dir_cnt_in  = dir_cnt_ff + 1'b1;
            if (dir_cnt_ff == DIR_W'(DIR_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         // take a beat and start the directory read
         S_IDLE: begin
            req_stall = 1'b0;
            dir_rd_en = 1'b1;
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               didx_in   = dir_rd_addr;
               tidx_in   = TE_W'(idx_mod(req_virt_addr[21:12], TABLE_ENTRIES));
               pframe_in = req_phys_frame[FRAME_BITS-1:0];
               wr_in     = req_write_allowed;
               create_in = req_create_table;
               state_in  = S_DIR_CHK;
            end
         end
         // check the directory entry, allocate a table on demand
         S_DIR_CHK: begin
            res_status_in  = ST_OK;
            res_frame_in   = '0;
            res_present_in = 1'b0;
            res_rw_in      = 1'b0;
            res_user_in    = 1'b0;
            if (cmd_ff == CMD_NOP) begin
               state_in = S_RESP;
            end else if (dir_rd_data[TAB_W]) begin
               tab_in   = dir_rd_data[TAB_W-1:0];
               state_in = S_ENT_RD;
            end else if (cmd_ff == CMD_MAP || (cmd_ff == CMD_LOOKUP && create_ff)) begin
               if (pool_full) begin
                  res_status_in = ST_EXHAUSTED;
                  state_in      = S_RESP;
               end else begin
                  tab_in       = TAB_W'(next_free_ff);
                  next_free_in = next_free_ff + 1'b1;
                  dir_wr_en    = 1'b1;
                  dir_wr_data  = {1'b1, TAB_W'(next_free_ff)};
                  clr_cnt_in   = '0;
                  state_in     = S_CLEAR_TAB;
               end
            end else begin
               res_status_in = ST_NO_TABLE;
               state_in      = S_RESP;
            end
         end
         // sweep the new table clear
         S_CLEAR_TAB: begin
            ent_wr_en  = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == TE_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_ENT_RD;
            end
         end
         // read the entry
         S_ENT_RD: begin
            ent_rd_en = 1'b1;
            state_in  = S_ENT_CHK;
         end
         // modify and write back the entry
         S_ENT_CHK: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_MAP: begin
                  if (ent_rd_data[P_BIT]) begin
                     res_status_in = ST_MAPPED;
                  end else begin
                     ent_wr_en   = 1'b1;
                     ent_wr_data = {~kctx_ff, wr_ff, 1'b1, pframe_ff};
                  end
               end
               CMD_UNMAP: begin
                  if (!ent_rd_data[P_BIT]) begin
                     res_status_in = ST_NOT_MAPPED;
                  end else begin
                     res_frame_in = ent_rd_data[FRAME_BITS-1:0];
                     ent_wr_en    = 1'b1;
                     ent_wr_data  = {ent_rd_data[U_BIT], ent_rd_data[W_BIT], 1'b0,
                                     {FRAME_BITS{1'b0}}};
                  end
               end
               CMD_LOOKUP: begin
                  res_frame_in   = ent_rd_data[FRAME_BITS-1:0];
                  res_present_in = ent_rd_data[P_BIT];
                  res_rw_in      = ent_rd_data[W_BIT];
                  res_user_in    = ent_rd_data[U_BIT];
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         // load the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_frame_in   = res_frame_ff;
               rsp_present_in = res_present_ff;
               rsp_rw_in      = res_rw_ff;
               rsp_user_in    = res_user_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // drive the result channel
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_frame       = FRAME_W'(rsp_frame_ff);
   assign rsp_present     = rsp_present_ff;
   assign rsp_writable    = rsp_rw_ff;
   assign rsp_user_access = rsp_user_ff;
   assign rsp_accessed    = 1'b0;
   assign rsp_dirty       = 1'b0;

   assign mon.clearing  = (state_ff == S_CLEAR_DIR);
   assign mon.pool_full = pool_full;

endmodule
`default_nettype wire

>>> design/two_level_page_table_update_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// two_level_page_table_update_top
// Two-level page table kept in a directory RAM and an entry RAM.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat (map, unmap, lookup, no-op) with its
//   virtual address, frame and flags; rsp_* returns one status beat per
//   command. csr_write_en/csr_write_data set the kernel-context bit; the
//   user must see that they are written only while the block is idle, as
//   the block itself does not enforce it. Commands run one at a time.
//   For a command whose directory entry exists, rsp_valid rises after the
//   directory check, entry read, entry write-back and result load; the
//   next beat can be taken in that same cycle. A no-op or a failed
//   directory check goes straight from the check to the result load.
//   Allocating a table first clears it, one entry cleared per cycle
//   through the single entry RAM write port.
//   After reset the directory RAM is swept clear with req_stall high; the
//   kernel-context bit resets to 1.
//   The result sits in an output register: a new command is accepted while
//   it waits, but the next result is held until rsp_stall drops.
// ---------------------------------------------------------------------------
module two_level_page_table_update_top #(
   parameter int unsigned DIR_ENTRIES   = ptu_pkg::DIR_ENTRIES_DEF,
   parameter int unsigned TABLE_ENTRIES = ptu_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned TABLE_POOL    = ptu_pkg::TABLE_POOL_DEF,
   parameter int unsigned FRAME_BITS    = ptu_pkg::FRAME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic                          csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [ptu_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [31:0]                   req_virt_addr,
   input  wire logic [ptu_pkg::FRAME_W-1:0]   req_phys_frame,
   input  wire logic                          req_write_allowed,
   input  wire logic                          req_create_table,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ptu_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ptu_pkg::FRAME_W-1:0]        rsp_frame,
   output logic                               rsp_present,
   output logic                               rsp_writable,
   output logic                               rsp_user_access,
   output logic                               rsp_accessed,
   output logic                               rsp_dirty
);

   import ptu_pkg::*;

   localparam int unsigned DIR_W     = $clog2(DIR_ENTRIES);
   localparam int unsigned TE_W      = $clog2(TABLE_ENTRIES);
   localparam int unsigned TAB_W     = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
   localparam int unsigned ENT_DEPTH = TABLE_POOL * TABLE_ENTRIES;
   localparam int unsigned ENT_AW    = $clog2(ENT_DEPTH);
   localparam int unsigned ENT_W     = FRAME_BITS + 3;

   logic                 dir_wr_en;
   logic [DIR_W-1:0]     dir_wr_addr;
   logic [TAB_W:0]       dir_wr_data;
   logic                 dir_rd_en;
   logic [DIR_W-1:0]     dir_rd_addr;
   logic [TAB_W:0]       dir_rd_data;
   logic                 ent_wr_en;
   logic [ENT_AW-1:0]    ent_addr;
   logic [ENT_W-1:0]     ent_wr_data;
   logic                 ent_rd_en;
   logic [ENT_W-1:0]     ent_rd_data;
   mon_type              mon;

   // directory: valid bit and table number per entry
   ptu_ram #(
      .DEPTH (DIR_ENTRIES),
      .WIDTH (TAB_W + 1),
      .AW    (DIR_W)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_en   (dir_rd_en),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rd_data)
   );

   // second-level tables of the pool, back to back
   ptu_ram #(
      .DEPTH (ENT_DEPTH),
      .WIDTH (ENT_W),
      .AW    (ENT_AW)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_addr),
      .rd_data (ent_rd_data)
   );

   ptu_ctrl #(
      .DIR_ENTRIES   (DIR_ENTRIES),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TABLE_POOL    (TABLE_POOL),
      .FRAME_BITS    (FRAME_BITS),
      .DIR_W         (DIR_W),
      .TE_W          (TE_W),
      .TAB_W         (TAB_W),
      .ENT_AW        (ENT_AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_virt_addr     (req_virt_addr),
      .req_phys_frame    (req_phys_frame),
      .req_write_allowed (req_write_allowed),
      .req_create_table  (req_create_table),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_frame         (rsp_frame),
      .rsp_present       (rsp_present),
      .rsp_writable      (rsp_writable),
      .rsp_user_access   (rsp_user_access),
      .rsp_accessed      (rsp_accessed),
      .rsp_dirty         (rsp_dirty),
      .dir_wr_en         (dir_wr_en),
      .dir_wr_addr       (dir_wr_addr),
      .dir_wr_data       (dir_wr_data),
      .dir_rd_en         (dir_rd_en),
      .dir_rd_addr       (dir_rd_addr),
      .dir_rd_data       (dir_rd_data),
      .ent_wr_en         (ent_wr_en),
      .ent_addr          (ent_addr),
      .ent_wr_data       (ent_wr_data),
      .ent_rd_en         (ent_rd_en),
      .ent_rd_data       (ent_rd_data),
      .mon               (mon)
   );

   // no beat is taken during the directory clear sweep
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      mon.clearing |-> req_stall)
      else $error("request taken during directory clear");

   // one command at a time: the cycle after a beat is stalled
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat taken while a command is in flight");

   // exhaustion is reported only with the pool used up
   a_exhausted_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EXHAUSTED) |-> mon.pool_full)
      else $error("pool exhausted reported with free tables");

endmodule
`default_nettype wire
